/* hdl/itf_pkg.sv */
// Shared types and constants for the integer-to-text formatter.
// Used by itf_digit_gen, itf_char_seq and integer_to_text_formatter_core; no dependencies.
`default_nettype none

package itf_pkg;

  // Counts of characters, digits and padding all fit in this width.
  localparam int CNT_W = 8;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_HEX = 5'd16;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_O = 8'h4F;
  localparam logic [7:0] CH_LOWER_O = 8'h6F;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } ctl_state_t;

  // Sections of the output text, in the order they are sent.
  typedef enum logic [2:0] {
    PH_LSPACE = 3'd0,
    PH_SIGN   = 3'd1,
    PH_PFX0   = 3'd2,
    PH_PFX1   = 3'd3,
    PH_ZERO   = 3'd4,
    PH_DIGIT  = 3'd5,
    PH_RSPACE = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef struct packed {
    logic       busy;
    cnt_t       ndig;
  } dg_status_t;

  typedef struct packed {
    logic       has_sign;
    logic [7:0] sign_char;
    logic       has_prefix;
    logic [7:0] prefix_char;
    logic       upper;
    cnt_t       lpad;
    cnt_t       zpad;
    cnt_t       rpad;
    cnt_t       ndig;
  } fmt_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0000, d};
    end else begin
      digit_char = base + {4'b0000, d} - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/itf_digit_gen.sv */
// Bit-serial radix conversion: restoring division by the radix, one bit per cycle,
// with the digits pushed onto a shift-register stack. Depends on itf_pkg.
`default_nettype none

module itf_digit_gen #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] mag,
  input  wire logic [4:0]            radix,
  input  wire logic                  pop,
  output logic [3:0]                 top_digit,
  output itf_pkg::dg_status_t        status
);
  import itf_pkg::*;

  localparam int BIT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quo;
  logic [3:0]            rem;
  logic [BIT_W-1:0]      bit_cnt;
  logic                  busy;
  cnt_t                  ndig;
  logic [3:0]            stack [VALUE_BITS];

  logic [4:0]            trial;
  logic                  ge;
  logic [4:0]            rem_step;
  logic [VALUE_BITS-1:0] quo_step;
  logic                  pass_end;

  // The remainder stays below the radix, so four bits hold it between steps.
  always_comb begin
    trial    = {rem, quo[VALUE_BITS-1]};
    ge       = (trial >= radix);
    rem_step = ge ? (trial - radix) : trial;
    quo_step = {quo[VALUE_BITS-2:0], ge};
    pass_end = (bit_cnt == BIT_W'(VALUE_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ndig <= '0;
    end else if (start) begin
      busy <= 1'b1;
      ndig <= '0;
    end else if (busy && pass_end) begin
      ndig <= ndig + cnt_t'(1);
      if (quo_step == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= mag;
      rem     <= '0;
      bit_cnt <= '0;
    end else if (busy) begin
      quo <= quo_step;
      if (pass_end) begin
        rem     <= '0;
        bit_cnt <= '0;
        stack[0] <= rem_step[3:0];
        for (int i = 1; i < VALUE_BITS; i++) begin
          stack[i] <= stack[i-1];
        end
      end else begin
        rem     <= rem_step[3:0];
        bit_cnt <= bit_cnt + BIT_W'(1);
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  assign top_digit   = stack[0];
  assign status.busy = busy;
  assign status.ndig = ndig;

endmodule

`default_nettype wire

/* hdl/itf_char_seq.sv */
// Character sequencer: walks leading padding, sign, prefix, zero padding, digits and trailing
// padding, one character per cycle while out_ready allows, into an output register. Depends on itf_pkg.
`default_nettype none

module itf_char_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire itf_pkg::fmt_t fmt,
  input  wire logic [3:0]    top_digit,
  output logic               pop,
  output logic               busy,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_char,
  output logic               last
);
  import itf_pkg::*;

  phase_t     phase;
  cnt_t       cnt;
  fmt_t       f;

  logic [7:0] mask_in;
  logic [7:0] mask_cur;
  phase_t     first_ph;
  phase_t     nxt;
  logic       adv;
  logic       fire;
  logic       stay;
  logic       last_now;
  logic [7:0] ch;

  // One bit per section that has at least one character, plus an always-set bit for PH_DONE.
  function automatic logic [7:0] section_mask(input fmt_t x);
    section_mask = {1'b1, (x.rpad != '0), 1'b1, (x.zpad != '0),
                    x.has_prefix, x.has_prefix, x.has_sign, (x.lpad != '0)};
  endfunction

  function automatic phase_t first_phase(input logic [7:0] mask, input logic [2:0] from);
    phase_t res;
    res = PH_DONE;
    for (int i = 7; i >= 0; i--) begin
      if ((3'(i) >= from) && mask[i]) begin
        res = phase_t'(3'(i));
      end
    end
    first_phase = res;
  endfunction

  function automatic cnt_t phase_len(input phase_t p, input fmt_t x);
    case (p)
      PH_LSPACE: phase_len = x.lpad;
      PH_ZERO:   phase_len = x.zpad;
      PH_DIGIT:  phase_len = x.ndig;
      PH_RSPACE: phase_len = x.rpad;
      default:   phase_len = cnt_t'(1);
    endcase
  endfunction

  always_comb begin
    mask_in  = section_mask(fmt);
    mask_cur = section_mask(f);
    first_ph = first_phase(mask_in, 3'd0);
    adv      = !out_valid || out_ready;
    fire     = adv && (phase != PH_DONE);
    stay     = (cnt > cnt_t'(1));
    nxt      = stay ? phase : first_phase(mask_cur, phase + 3'd1);
    last_now = !stay && (nxt == PH_DONE);
    pop      = fire && (phase == PH_DIGIT);
    busy     = (phase != PH_DONE);
    unique case (phase) inside
      PH_LSPACE, PH_RSPACE: ch = CH_SPACE;
      PH_SIGN:              ch = f.sign_char;
      PH_PFX0, PH_ZERO:     ch = CH_ZERO;
      PH_PFX1:              ch = f.prefix_char;
      PH_DIGIT:             ch = digit_char(top_digit, f.upper);
      default:              ch = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DONE;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        phase <= first_ph;
      end else if (fire) begin
        phase <= nxt;
      end
      if (adv) begin
        out_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      f   <= fmt;
      cnt <= phase_len(first_ph, fmt);
    end else if (fire) begin
      cnt <= stay ? (cnt - cnt_t'(1)) : phase_len(nxt, f);
    end
    if (fire) begin
      out_char <= ch;
      last     <= last_now;
    end
  end

endmodule

`default_nettype wire

/* hdl/integer_to_text_formatter_core.sv */
// Integer-to-text formatter, top level. Depends on itf_pkg, itf_digit_gen, itf_char_seq.
// One item at a time: the one-bit-per-cycle divider first produces every digit, then
// the sequencer sends the characters, and a new item is accepted only once the last
// character has entered the output register, even if it still waits for out_ready.
// Synchronous active-high reset clears the controller, the divider and the output valid.
`default_nettype none

module integer_to_text_formatter_core #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 63
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic [4:0]            radix,
  input  wire logic [5:0]            pad_width,
  input  wire logic                  width_enable,
  input  wire logic                  signed_mode,
  input  wire logic                  left_justify,
  input  wire logic                  force_plus,
  input  wire logic                  space_sign,
  input  wire logic                  alt_prefix,
  input  wire logic                  zero_pad,
  input  wire logic                  upper_case,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_char,
  output logic                       last
);
  import itf_pkg::*;

  ctl_state_t            state;
  ctl_state_t            state_next;

  logic [4:0]            radix_r;
  logic [5:0]            width_r;
  logic                  wen_r;
  logic                  neg_r;
  logic                  left_r;
  logic                  plus_r;
  logic                  spc_r;
  logic                  alt_r;
  logic                  zpad_r;
  logic                  upper_r;

  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;
  logic [4:0]            radix_in;
  logic                  dg_start;
  logic                  cs_start;
  logic                  cs_busy;
  logic                  pop;
  logic [3:0]            top_digit;
  dg_status_t            dg_status;
  fmt_t                  fmt;
  cnt_t                  body;
  cnt_t                  width_eff;
  cnt_t                  pad;

  always_comb begin
    neg_in = signed_mode && value[VALUE_BITS-1];
    mag_in = neg_in ? (~value + VALUE_BITS'(1)) : value;
    if (radix < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = radix;
    end
  end

  // Format descriptor, built once the digit count is known.
  always_comb begin
    fmt.has_sign    = neg_r || plus_r || spc_r;
    fmt.sign_char   = neg_r ? CH_MINUS : (plus_r ? CH_PLUS : CH_SPACE);
    fmt.has_prefix  = alt_r && ((radix_r == RADIX_OCT) || (radix_r == RADIX_HEX));
    if (radix_r == RADIX_OCT) begin
      fmt.prefix_char = upper_r ? CH_UPPER_O : CH_LOWER_O;
    end else begin
      fmt.prefix_char = upper_r ? CH_UPPER_X : CH_LOWER_X;
    end
    fmt.upper = upper_r;
    fmt.ndig  = dg_status.ndig;
    body = dg_status.ndig + cnt_t'(fmt.has_sign) + (fmt.has_prefix ? cnt_t'(2) : cnt_t'(0));
    width_eff = cnt_t'(width_r);
    if (width_eff > cnt_t'(MAX_WIDTH)) begin
      width_eff = cnt_t'(MAX_WIDTH);
    end
    pad = (wen_r && (width_eff > body)) ? (width_eff - body) : cnt_t'(0);
    fmt.lpad = (!left_r && !zpad_r) ? pad : cnt_t'(0);
    fmt.zpad = (!left_r && zpad_r) ? pad : cnt_t'(0);
    fmt.rpad = left_r ? pad : cnt_t'(0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    dg_start   = 1'b0;
    cs_start   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dg_start   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (!dg_status.busy) begin
          cs_start   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!cs_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dg_start) begin
      radix_r <= radix_in;
      width_r <= pad_width;
      wen_r   <= width_enable;
      neg_r   <= neg_in;
      left_r  <= left_justify;
      plus_r  <= force_plus;
      spc_r   <= space_sign;
      alt_r   <= alt_prefix;
      zpad_r  <= zero_pad;
      upper_r <= upper_case;
    end
  end

  itf_digit_gen #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digit_gen (
    .clk       (clk),
    .rst       (rst),
    .start     (dg_start),
    .mag       (mag_in),
    .radix     (radix_r),
    .pop       (pop),
    .top_digit (top_digit),
    .status    (dg_status)
  );

  itf_char_seq u_char_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (cs_start),
    .fmt       (fmt),
    .top_digit (top_digit),
    .pop       (pop),
    .busy      (cs_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
  );

endmodule

`default_nettype wire
